// ----- rtl/running_mean_variance_unit_assert.svh -----
// assertion macros used by the checker file
`ifndef RUNNING_MEAN_VARIANCE_UNIT_ASSERT_SVH
`define RUNNING_MEAN_VARIANCE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RMV_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("rmv assertion failed");

// next-cycle implication, disabled while in reset
`define RMV_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("rmv assertion failed");

`endif

// ----- rtl/rmv_pkg.sv -----
// shared constants, types and codes of the running mean and variance unit
package rmv_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int COUNT_BITS    = 16;
  localparam int FRAC_BITS     = 16;
  localparam int MEAN_BITS     = SAMPLE_BITS + FRAC_BITS;
  localparam int VAR_BITS      = 2 * SAMPLE_BITS + FRAC_BITS;
  localparam int WIDE_BITS     = 2 * MEAN_BITS;
  localparam int STEP_BITS     = $clog2(WIDE_BITS + 1);
  localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((MEAN_BITS + VAR_BITS + COUNT_BITS + 7) / 8) * 8;

  // field positions inside out_tdata
  localparam int OUT_MEAN_LO = 0;
  localparam int OUT_VAR_LO  = MEAN_BITS;
  localparam int OUT_CNT_LO  = MEAN_BITS + VAR_BITS;

  // step counts of the shift unit per operation
  localparam logic [STEP_BITS-1:0] STEPS_MAG  = STEP_BITS'(MEAN_BITS);
  localparam logic [STEP_BITS-1:0] STEPS_VAR  = STEP_BITS'(VAR_BITS);
  localparam logic [STEP_BITS-1:0] STEPS_CNT  = STEP_BITS'(COUNT_BITS);
  localparam logic [STEP_BITS-1:0] STEPS_WIDE = STEP_BITS'(WIDE_BITS);

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } su_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_MDIV,
    ST_SQ,
    ST_SDIV,
    ST_VMUL,
    ST_VDIV,
    ST_OUT
  } core_state_t;

  typedef struct packed {
    logic                 start;
    su_op_t               op;
    logic [WIDE_BITS-1:0] opnd;
    logic [WIDE_BITS-1:0] load;
    logic [STEP_BITS-1:0] steps;
  } su_cmd_t;

  typedef struct packed {
    logic                 done;
    logic [WIDE_BITS-1:0] acc;
    logic [WIDE_BITS-1:0] quo;
  } su_rsp_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } rmv_status_t;

  typedef struct packed {
    logic                  saturated;
    logic [COUNT_BITS-1:0] count;
    logic [VAR_BITS-1:0]   variance;
    logic [MEAN_BITS-1:0]  mean;
  } rmv_result_t;

endpackage

// ----- rtl/rmv_shift_unit.sv -----
// radix-2 shift and add/subtract unit for multiplication and unsigned division
module rmv_shift_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  rmv_pkg::su_cmd_t cmd,
  output rmv_pkg::su_rsp_t rsp
);
  import rmv_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [STEP_BITS-1:0] cnt_r, cnt_nxt;
  su_op_t               op_r, op_nxt;
  logic [WIDE_BITS-1:0] opnd_r, opnd_nxt;
  logic [WIDE_BITS-1:0] acc_r, acc_nxt;
  logic [WIDE_BITS-1:0] q_r, q_nxt;

  logic [WIDE_BITS-1:0] shifted;
  logic [WIDE_BITS:0]   operand_b;
  logic [WIDE_BITS:0]   res;
  logic                 take;

  // one wide adder: add for multiply, trial subtract for divide
  always_comb begin
    shifted   = {acc_r[WIDE_BITS-2:0], (op_r == OP_DIV) ? q_r[WIDE_BITS-1] : 1'b0};
    operand_b = (op_r == OP_DIV) ? ~{1'b0, opnd_r}
              : (q_r[WIDE_BITS-1] ? {1'b0, opnd_r} : '0);
    res       = {1'b0, shifted} + operand_b + (WIDE_BITS + 1)'(op_r == OP_DIV);
    take      = ~res[WIDE_BITS];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    opnd_nxt = opnd_r;
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = cmd.steps;
      op_nxt   = cmd.op;
      opnd_nxt = cmd.opnd;
      acc_nxt  = '0;
      q_nxt    = cmd.load;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - STEP_BITS'(1);
      if (cnt_r == STEP_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      unique case (op_r)
        OP_DIV: begin
          acc_nxt = take ? res[WIDE_BITS-1:0] : shifted;
          q_nxt   = {q_r[WIDE_BITS-2:0], take};
        end
        OP_MUL: begin
          acc_nxt = res[WIDE_BITS-1:0];
          q_nxt   = {q_r[WIDE_BITS-2:0], 1'b0};
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    op_r   <= op_nxt;
    opnd_r <= opnd_nxt;
    acc_r  <= acc_nxt;
    q_r    <= q_nxt;
  end

  assign rsp = '{done: done_r, acc: acc_r, quo: q_r};

endmodule

// ----- rtl/rmv_core.sv -----
// sequencer and state registers of the welford update around the shift unit
module rmv_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   take,
  input  logic signed [rmv_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   restart,
  input  logic                                   res_take,
  output rmv_pkg::rmv_status_t                   status,
  output rmv_pkg::rmv_result_t                   result
);
  import rmv_pkg::*;

  core_state_t            state_r, state_nxt;
  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [MEAN_BITS-1:0]   mean_r, mean_nxt;
  logic [VAR_BITS-1:0]    var_r, var_nxt;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;
  logic                   neg_r, neg_nxt;
  logic [MEAN_BITS-1:0]   mag_r, mag_nxt;
  logic [VAR_BITS-1:0]    d2_r, d2_nxt;
  logic [VAR_BITS-1:0]    scaled_r, scaled_nxt;

  su_cmd_t cmd;
  su_rsp_t rsp;

  logic [MEAN_BITS-1:0]  sample_fx;
  logic [MEAN_BITS:0]    delta_c;
  logic [MEAN_BITS-1:0]  mag_c;
  logic [COUNT_BITS:0]   n_plus1;
  logic [COUNT_BITS-1:0] n_div;
  logic [COUNT_BITS-1:0] nm1;
  logic [MEAN_BITS+1:0]  qext;
  logic [MEAN_BITS+1:0]  qsigned;
  logic [MEAN_BITS+1:0]  mean_sum;
  logic [MEAN_BITS-1:0]  newmean_c;
  logic [VAR_BITS-1:0]   d2_c;
  logic [VAR_BITS-1:0]   scaled_c;
  logic [WIDE_BITS-1:0]  ssr_c;
  logic [VAR_BITS-1:0]   var_c;

  rmv_shift_unit u_shift (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rsp   (rsp)
  );

  always_comb begin
    sample_fx = {sample_r, {FRAC_BITS{1'b0}}};
    delta_c   = {sample_fx[MEAN_BITS-1], sample_fx} - {mean_r[MEAN_BITS-1], mean_r};
    mag_c     = delta_c[MEAN_BITS] ? (~delta_c[MEAN_BITS-1:0] + MEAN_BITS'(1))
                                   : delta_c[MEAN_BITS-1:0];
    n_plus1   = {1'b0, count_r} + (COUNT_BITS + 1)'(1);
    n_div     = (count_r == '0) ? COUNT_BITS'(1) : count_r;
    nm1       = (count_r == '0) ? '0 : count_r - COUNT_BITS'(1);

    // mean plus the truncated signed quotient, clamped to the mean width
    qext      = {2'b00, rsp.quo[MEAN_BITS-1:0]};
    qsigned   = neg_r ? (~qext + (MEAN_BITS + 2)'(1)) : qext;
    mean_sum  = {{2{mean_r[MEAN_BITS-1]}}, mean_r} + qsigned;
    if ((mean_sum[MEAN_BITS+1] == mean_sum[MEAN_BITS]) &&
        (mean_sum[MEAN_BITS] == mean_sum[MEAN_BITS-1])) begin
      newmean_c = mean_sum[MEAN_BITS-1:0];
    end else if (mean_sum[MEAN_BITS+1]) begin
      newmean_c = {1'b1, {(MEAN_BITS-1){1'b0}}};
    end else begin
      newmean_c = {1'b0, {(MEAN_BITS-1){1'b1}}};
    end

    // squared delta back to frac bits, then d - ceil(d/(n+1))
    d2_c     = rsp.acc[FRAC_BITS +: VAR_BITS];
    scaled_c = d2_r - rsp.quo[VAR_BITS-1:0] - VAR_BITS'(rsp.acc != '0);
    ssr_c    = rsp.acc + WIDE_BITS'(scaled_r);
    var_c    = (rsp.quo[WIDE_BITS-1:VAR_BITS] != '0) ? '1 : rsp.quo[VAR_BITS-1:0];
  end

  always_comb begin
    state_nxt  = state_r;
    sample_nxt = sample_r;
    mean_nxt   = mean_r;
    var_nxt    = var_r;
    count_nxt  = count_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    d2_nxt     = d2_r;
    scaled_nxt = scaled_r;
    cmd        = '0;
    status     = '{idle: 1'b0, res_valid: 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        status.idle = 1'b1;
        if (take) begin
          sample_nxt = sample;
          if (restart) begin
            mean_nxt  = '0;
            var_nxt   = '0;
            count_nxt = '0;
          end
          state_nxt = ST_DELTA;
        end
      end
      ST_DELTA: begin
        neg_nxt   = delta_c[MEAN_BITS];
        mag_nxt   = mag_c;
        cmd.start = 1'b1;
        cmd.op    = OP_DIV;
        cmd.load  = {mag_c, {(WIDE_BITS-MEAN_BITS){1'b0}}};
        cmd.opnd  = WIDE_BITS'(n_plus1);
        cmd.steps = STEPS_MAG;
        state_nxt = ST_MDIV;
      end
      ST_MDIV: begin
        if (rsp.done) begin
          mean_nxt  = newmean_c;
          cmd.start = 1'b1;
          cmd.op    = OP_MUL;
          cmd.load  = {mag_r, {(WIDE_BITS-MEAN_BITS){1'b0}}};
          cmd.opnd  = WIDE_BITS'(mag_r);
          cmd.steps = STEPS_MAG;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (rsp.done) begin
          d2_nxt    = d2_c;
          cmd.start = 1'b1;
          cmd.op    = OP_DIV;
          cmd.load  = {d2_c, {(WIDE_BITS-VAR_BITS){1'b0}}};
          cmd.opnd  = WIDE_BITS'(n_plus1);
          cmd.steps = STEPS_VAR;
          state_nxt = ST_SDIV;
        end
      end
      ST_SDIV: begin
        if (rsp.done) begin
          scaled_nxt = scaled_c;
          cmd.start  = 1'b1;
          cmd.op     = OP_MUL;
          cmd.load   = {nm1, {(WIDE_BITS-COUNT_BITS){1'b0}}};
          cmd.opnd   = WIDE_BITS'(var_r);
          cmd.steps  = STEPS_CNT;
          state_nxt  = ST_VMUL;
        end
      end
      ST_VMUL: begin
        if (rsp.done) begin
          cmd.start = 1'b1;
          cmd.op    = OP_DIV;
          cmd.load  = ssr_c;
          cmd.opnd  = WIDE_BITS'(n_div);
          cmd.steps = STEPS_WIDE;
          state_nxt = ST_VDIV;
        end
      end
      ST_VDIV: begin
        if (rsp.done) begin
          var_nxt = var_c;
          if (count_r != '1) begin
            count_nxt = count_r + COUNT_BITS'(1);
          end
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        status.res_valid = 1'b1;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mean_r  <= '0;
      var_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      mean_r  <= mean_nxt;
      var_r   <= var_nxt;
      count_r <= count_nxt;
    end
    sample_r <= sample_nxt;
    neg_r    <= neg_nxt;
    mag_r    <= mag_nxt;
    d2_r     <= d2_nxt;
    scaled_r <= scaled_nxt;
  end

  assign result = '{saturated: (count_r == '1), count: count_r,
                    variance: var_r, mean: mean_r};

endmodule

// ----- rtl/running_mean_variance_unit.sv -----
// top level of the running mean and unbiased variance unit
// each request carries one signed integer sample; the unit folds it into the
// running mean, the unbiased sample variance and a saturating count, and
// returns all three as one result request. a new request is not taken until
// the update of the previous one is done: it is carried out by a single
// radix-2 shift and add/subtract unit, one bit per cycle, over five
// operations (32-step divide, 32-step square, 48-step divide, 16-step
// multiply, 64-step divide). the result sits in an output register, so the
// next request is taken while the previous result waits on out_tready. a
// set restart bit clears mean, variance and count before its own sample is
// used
module running_mean_variance_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // input request channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rmv_pkg::IN_DATA_BITS-1:0]    in_tdata,   // [15:0] sample
  input  logic                                in_tuser,   // [0] restart
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rmv_pkg::OUT_DATA_BITS-1:0]   out_tdata,  // [31:0] mean, [79:32] variance,
                                                          // [95:80] count
  output logic                                out_tuser   // [0] count_saturated
);
  import rmv_pkg::*;

  rmv_status_t status;
  rmv_result_t result;
  logic        in_take;
  logic        res_take;

  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_DATA_BITS-1:0] out_data_r, out_data_nxt;
  logic                     out_sat_r, out_sat_nxt;

  // request taken only while the sequencer is idle
  assign in_tready = status.idle;
  assign in_take   = in_tvalid & in_tready;

  rmv_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (in_take),
    .sample   (in_tdata[SAMPLE_BITS-1:0]),
    .restart  (in_tuser),
    .res_take (res_take),
    .status   (status),
    .result   (result)
  );

  // output register: loads a waiting result when empty or being drained this cycle
  always_comb begin
    res_take      = status.res_valid & (~out_valid_r | out_tready);
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_sat_nxt   = out_sat_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_DATA_BITS'({result.count, result.variance, result.mean});
      out_sat_nxt   = result.saturated;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule

// ----- rtl/rmv_checker.sv -----
// port-level assertions for the running mean and variance unit, with its bind
`include "running_mean_variance_unit_assert.svh"

module rmv_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [rmv_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input logic                              out_tuser
);
  import rmv_pkg::*;

  logic [COUNT_BITS-1:0] cnt_w;
  logic [VAR_BITS-1:0]   var_w;

  assign cnt_w = out_tdata[OUT_CNT_LO +: COUNT_BITS];
  assign var_w = out_tdata[OUT_VAR_LO +: VAR_BITS];

  // a taken request keeps the unit busy
  `RMV_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // a stalled result holds
  `RMV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // saturation flag matches a full count
  `RMV_ASSERT_NOW(a_sat_flag, clk, rst_n, out_tvalid, out_tuser == (cnt_w == '1))

  // a single sample gives zero variance
  `RMV_ASSERT_NOW(a_first_var, clk, rst_n, out_tvalid && (cnt_w == COUNT_BITS'(1)), var_w == '0)

endmodule

bind running_mean_variance_unit rmv_checker u_rmv_checker (.*);
